/* hw/rtl/sto_pkg.sv */
// Shared types and codes for the sorted timeout queue.
package sto_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_CHECK  = 1'b1;

    localparam int DL_W      = 32;
    localparam int ID_FIELD_W = 8;
    localparam int ID_MAX_W  = 16;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_EXPIRED  = 2'd3
    } t_status;

    typedef struct packed {
        logic    load;
        logic    exec;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic op;
        logic full;
        logic empty;
        logic head_due;
    } t_dp_stat;

endpackage

/* hw/rtl/sto_in_if.sv */
// Input channel: one insert or check request per transfer.
interface sto_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  entry_id;
    logic [31:0] delay;
    logic [31:0] now_time;

    modport source (output valid, output opcode, output entry_id, output delay,
                    output now_time, input ready);
    modport sink   (input valid, input opcode, input entry_id, input delay,
                    input now_time, output ready);
endinterface

/* hw/rtl/sto_out_if.sv */
// Output channel: one result per transfer.
interface sto_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  expired_id;
    logic [31:0] expired_deadline;
    logic        queue_empty;

    modport source (output valid, output status, output expired_id,
                    output expired_deadline, output queue_empty, input ready);
    modport sink   (input valid, input status, input expired_id,
                    input expired_deadline, input queue_empty, output ready);
endinterface

/* hw/rtl/sto_datapath.sv */
// Datapath: request capture, sorted register chain and result register.
module sto_datapath
    import sto_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_dp_cmd         i_cmd,
    output t_dp_stat        o_stat,
    input  logic            i_opcode,
    input  logic [7:0]      i_entry_id,
    input  logic [31:0]     i_delay,
    input  logic [31:0]     i_now_time,
    output logic [1:0]      o_status,
    output logic [7:0]      o_expired_id,
    output logic [31:0]     o_expired_deadline,
    output logic            o_queue_empty
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                r_op;
    logic [ID_WIDTH-1:0] r_id;
    logic [DL_W-1:0]     r_dl;
    logic [DL_W-1:0]     r_now;

    logic [DL_W-1:0]     r_dl_q [QUEUE_DEPTH];
    logic [ID_WIDTH-1:0] r_id_q [QUEUE_DEPTH];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic [QUEUE_DEPTH-1:0] lt;
    logic [ID_MAX_W-1:0]    id_in_ext;
    logic [ID_MAX_W-1:0]    id_out_ext;

    assign id_in_ext  = ID_MAX_W'(i_entry_id);
    assign id_out_ext = ID_MAX_W'(r_id_q[0]);

    // Cells holding an earlier deadline than the new one stay put; they form a prefix.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            lt[i] = (CW'(i) < r_count) && (r_dl_q[i] < r_dl);
        end
    end

    assign o_stat.op       = r_op;
    assign o_stat.full     = (r_count == CW'(QUEUE_DEPTH));
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.head_due = (r_count != '0) && (r_dl_q[0] <= r_now);

    always_comb begin
        n_count = r_count;
        if (i_cmd.code == ST_INSERTED) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.code == ST_EXPIRED) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_id  <= id_in_ext[ID_WIDTH-1:0];
            r_dl  <= i_now_time + i_delay;
            r_now <= i_now_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (i_cmd.code == ST_INSERTED) begin
                for (int i = 0; i < QUEUE_DEPTH; i++) begin
                    if (!lt[i]) begin
                        if (i == 0) begin
                            r_dl_q[i] <= r_dl;
                            r_id_q[i] <= r_id;
                        end else if (lt[i-1]) begin
                            r_dl_q[i] <= r_dl;
                            r_id_q[i] <= r_id;
                        end else begin
                            r_dl_q[i] <= r_dl_q[i-1];
                            r_id_q[i] <= r_id_q[i-1];
                        end
                    end
                end
            end else if (i_cmd.code == ST_EXPIRED) begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    r_dl_q[i] <= r_dl_q[i+1];
                    r_id_q[i] <= r_id_q[i+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_status      <= i_cmd.code;
            o_queue_empty <= (n_count == '0);
            if (i_cmd.code == ST_EXPIRED) begin
                o_expired_id       <= id_out_ext[ID_FIELD_W-1:0];
                o_expired_deadline <= r_dl_q[0];
            end else begin
                o_expired_id       <= '0;
                o_expired_deadline <= '0;
            end
        end
    end

endmodule

/* hw/rtl/sto_ctrl.sv */
// Controller: intake and execute sequencing, result code, output valid.
module sto_ctrl
    import sto_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load = i_in_valid && (r_state == S_IDLE);
        o_cmd.exec = (r_state == S_EXEC) && out_free;
        if (i_stat.op == OP_INSERT) begin
            o_cmd.code = i_stat.full ? ST_FULL : ST_INSERTED;
        end else begin
            o_cmd.code = i_stat.head_due ? ST_EXPIRED : ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // The result register must be free before the queue is updated.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/sorted_timeout_queue.sv */
// Top level of the sorted timeout queue.
// A request is captured and its deadline formed; then, on execution, every
// cell of the sorted register chain compares its deadline with the new one
// and keeps, takes or shifts in parallel (or the chain shifts toward the head
// on an expiry). A new request is taken only after the last has executed, as
// long as the single result register is drained; a waiting result holds the
// execute state until it is taken. The queue holds QUEUE_DEPTH entries, the
// newest first among equal deadlines, and needs no clearing pass after reset.
module sorted_timeout_queue
    import sto_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sto_in_if.sink    i_in,
    sto_out_if.source o_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    sto_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sto_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_opcode           (i_in.opcode),
        .i_entry_id         (i_in.entry_id),
        .i_delay            (i_in.delay),
        .i_now_time         (i_in.now_time),
        .o_status           (o_out.status),
        .o_expired_id       (o_out.expired_id),
        .o_expired_deadline (o_out.expired_deadline),
        .o_queue_empty      (o_out.queue_empty)
    );

    a_intake_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request taken while another is in execution");

    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.full && stat.empty))
        else $error("queue reports full and empty at once");

    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec && cmd.code == ST_INSERTED) |=> !stat.empty)
        else $error("queue empty after an insert");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec && cmd.code == ST_FULL) |-> stat.full)
        else $error("insert rejected while the queue has room");

endmodule
